@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define HSLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication built on the clocked assertion above.
`define HSLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `HSLP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ src/hslp_pkg.sv @@
// Types, constants and helper functions of the start line parser.
package hslp_pkg;

  localparam int unsigned MaxLine    = 8192;
  localparam int unsigned CountW     = $clog2(MaxLine + 1);
  localparam int unsigned LenW       = 14;
  localparam int unsigned NumMethods = 8;

  // Character codes
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharTwo   = 8'h32;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    OutOk,
    OutNoFirstSpace,
    OutNoSecondSpace,
    OutBadVersion,
    OutBadStatus,
    OutCrNoLf,
    OutTooLong
  } outcome_e;

  // Method codes
  localparam logic [3:0] MethodUnknown = 4'd0;

  // Version codes
  localparam logic [1:0] VerNone = 2'd0;
  localparam logic [1:0] Ver10   = 2'd1;
  localparam logic [1:0] Ver11   = 2'd2;
  localparam logic [1:0] Ver20   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_item_t;

  typedef struct packed {
    outcome_e        outcome;
    logic [3:0]      method_code;
    logic [1:0]      version_code;
    logic [9:0]      status_number;
    logic [LenW-1:0] line_length;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // Method name, left justified, zero padded to eight characters.
  function automatic logic [63:0] method_name(input logic [2:0] idx);
    logic [63:0] name;
    case (idx)
      3'd0:    name = {"GET", 40'h0};
      3'd1:    name = {"HEAD", 32'h0};
      3'd2:    name = {"PUT", 40'h0};
      3'd3:    name = {"DELETE", 16'h0};
      3'd4:    name = {"OPTIONS", 8'h0};
      3'd5:    name = {"TRACE", 24'h0};
      3'd6:    name = {"POST", 32'h0};
      3'd7:    name = {"CONNECT", 8'h0};
      default: name = '0;
    endcase
    return name;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [63:0] shifted;
    shifted = method_name(idx) << {pos, 3'b000};
    return shifted[63:56];
  endfunction

  function automatic logic [2:0] method_len(input logic [2:0] idx);
    logic [2:0] len;
    case (idx)
      3'd0:    len = 3'd3;
      3'd1:    len = 3'd4;
      3'd2:    len = 3'd3;
      3'd3:    len = 3'd6;
      3'd4:    len = 3'd7;
      3'd5:    len = 3'd5;
      3'd6:    len = 3'd4;
      3'd7:    len = 3'd7;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] version_of(input logic [7:0] b);
    logic [1:0] v;
    case (b)
      CharZero: v = Ver10;
      CharOne:  v = Ver11;
      CharTwo:  v = Ver20;
      default:  v = VerNone;
    endcase
    return v;
  endfunction

  function automatic logic status_known(input logic [9:0] s);
    return (s == 10'd100) || (s == 10'd101) ||
           (s >= 10'd200 && s <= 10'd206) ||
           (s >= 10'd300 && s <= 10'd305) || (s == 10'd307) ||
           (s >= 10'd400 && s <= 10'd417) ||
           (s >= 10'd500 && s <= 10'd505);
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CharSpace) || (b == CharTab) || (b == CharLf) ||
           (b == CharVt) || (b == CharFf);
  endfunction

endpackage

@@ src/hslp_parser.sv @@
// Per-byte parse state and result decode of the start line parser.
module hslp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  hslp_pkg::in_item_t item_i,
  input  logic              kind_i,
  output hslp_pkg::result_t result_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhParse,
    PhDone
  } phase_e;

  typedef struct packed {
    logic ended;
    logic neg;
    logic digit;
    logic started;
  } scan_flags_t;

  phase_e                        phase_q, phase_d, phase_cur;
  logic [hslp_pkg::CountW-1:0]   count_q, count_d, count_cur, count_new;
  logic [hslp_pkg::NumMethods-1:0] mask_q, mask_d, mask_cur;
  logic                          first_sp_q, first_sp_d, first_sp_cur;
  logic                          later_sp_q, later_sp_d, later_sp_cur;
  logic [7:0]                    prev_q, prev_d, prev_cur;
  logic [7:0]                    ver_byte_q, ver_byte_d, ver_byte_cur;
  logic [9:0]                    acc_q, acc_d, acc_cur;
  scan_flags_t                   flags_q, flags_d, flags_cur;
  logic                          cr_q, cr_d, cr_cur;

  logic       start;
  logic       active;
  logic [7:0] b;
  logic       b_digit;
  logic [13:0] acc_next;
  logic [3:0] method_sel;
  logic [1:0] ver_req;
  logic [1:0] ver_rsp;
  hslp_pkg::result_t res;

  assign start = item_i.message_start;
  assign b     = item_i.data_byte;

  // Substitute a cleared parse when the byte opens a new message
  always_comb begin
    phase_cur    = start ? PhParse : phase_q;
    count_cur    = start ? '0 : count_q;
    mask_cur     = start ? '1 : mask_q;
    first_sp_cur = start ? 1'b0 : first_sp_q;
    later_sp_cur = start ? 1'b0 : later_sp_q;
    prev_cur     = start ? 8'h00 : prev_q;
    ver_byte_cur = start ? 8'h00 : ver_byte_q;
    acc_cur      = start ? 10'd0 : acc_q;
    flags_cur    = start ? scan_flags_t'('0) : flags_q;
    cr_cur       = start ? 1'b0 : cr_q;
  end

  assign active    = valid_i && (phase_cur == PhParse);
  assign count_new = count_cur + 1'b1;
  assign b_digit   = (b >= hslp_pkg::CharZero) && (b <= hslp_pkg::CharNine);
  assign acc_next  = {4'b0, acc_cur} * 14'd10 + {10'b0, 4'(b - hslp_pkg::CharZero)};

  // First still-matching method wins
  always_comb begin
    method_sel = hslp_pkg::MethodUnknown;
    for (int i = hslp_pkg::NumMethods - 1; i >= 0; i--) begin
      if (mask_cur[i]) begin
        method_sel = 4'(i + 1);
      end
    end
  end

  assign ver_req = hslp_pkg::version_of(prev_cur);
  assign ver_rsp = hslp_pkg::version_of(ver_byte_cur);

  // Next state and result for the byte in flight
  always_comb begin
    phase_d    = phase_cur;
    count_d    = count_cur;
    mask_d     = mask_cur;
    first_sp_d = first_sp_cur;
    later_sp_d = later_sp_cur;
    prev_d     = prev_cur;
    ver_byte_d = ver_byte_cur;
    acc_d      = acc_cur;
    flags_d    = flags_cur;
    cr_d       = cr_cur;

    res                    = '0;
    res.item.outcome       = hslp_pkg::OutOk;
    res.item.line_length   = hslp_pkg::LenW'(count_new);

    if (active) begin
      count_d = count_new;
      if (cr_cur) begin
        res.valid = 1'b1;
        if (b != hslp_pkg::CharLf) begin
          res.item.outcome = hslp_pkg::OutCrNoLf;
        end else if (!first_sp_cur) begin
          res.item.outcome = hslp_pkg::OutNoFirstSpace;
        end else if (!kind_i) begin
          if (!later_sp_cur) begin
            res.item.outcome = hslp_pkg::OutNoSecondSpace;
          end else if (ver_req == hslp_pkg::VerNone) begin
            res.item.outcome = hslp_pkg::OutBadVersion;
          end else begin
            res.item.method_code  = method_sel;
            res.item.version_code = ver_req;
          end
        end else begin
          if (ver_rsp == hslp_pkg::VerNone) begin
            res.item.outcome = hslp_pkg::OutBadVersion;
          end else if (!flags_cur.digit || flags_cur.neg ||
                       !hslp_pkg::status_known(acc_cur)) begin
            res.item.outcome = hslp_pkg::OutBadStatus;
          end else begin
            res.item.version_code  = ver_rsp;
            res.item.status_number = acc_cur;
          end
        end
      end else begin
        if (b == hslp_pkg::CharCr) begin
          cr_d = 1'b1;
        end else begin
          prev_d = b;
          if (!first_sp_cur) begin
            // Narrow the method candidates by this character
            if (b == hslp_pkg::CharSpace) begin
              first_sp_d = 1'b1;
              ver_byte_d = prev_cur;
              for (int i = 0; i < hslp_pkg::NumMethods; i++) begin
                if ({{(hslp_pkg::CountW-3){1'b0}}, hslp_pkg::method_len(3'(i))} != count_cur) begin
                  mask_d[i] = 1'b0;
                end
              end
            end else begin
              for (int i = 0; i < hslp_pkg::NumMethods; i++) begin
                if ({{(hslp_pkg::CountW-3){1'b0}}, hslp_pkg::method_len(3'(i))} <= count_cur) begin
                  mask_d[i] = 1'b0;
                end else if (hslp_pkg::method_char(3'(i), count_cur[2:0]) != b) begin
                  mask_d[i] = 1'b0;
                end
              end
            end
          end else begin
            if (b == hslp_pkg::CharSpace) begin
              later_sp_d = 1'b1;
            end
            // Status number scan
            if (!flags_cur.ended) begin
              if (!flags_cur.started) begin
                if (hslp_pkg::is_blank(b)) begin
                  flags_d = flags_cur;
                end else if (b == hslp_pkg::CharPlus || b == hslp_pkg::CharMinus) begin
                  flags_d.started = 1'b1;
                  flags_d.neg     = (b == hslp_pkg::CharMinus);
                end else if (b_digit) begin
                  flags_d.started = 1'b1;
                  flags_d.digit   = 1'b1;
                  acc_d           = 10'(b - hslp_pkg::CharZero);
                end else begin
                  flags_d.ended = 1'b1;
                end
              end else if (b_digit) begin
                acc_d         = (acc_next > 14'd1023) ? 10'd1023 : acc_next[9:0];
                flags_d.digit = 1'b1;
              end else begin
                flags_d.ended = 1'b1;
              end
            end
          end
        end
        if ({{(32-hslp_pkg::CountW){1'b0}}, count_new} >= hslp_pkg::MaxLine) begin
          res.valid        = 1'b1;
          res.item.outcome = hslp_pkg::OutTooLong;
        end
      end
      if (res.valid) begin
        phase_d = PhDone;
      end
    end
  end

  // Hold parse state; advance only on a byte in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      count_q    <= '0;
      mask_q     <= '1;
      first_sp_q <= 1'b0;
      later_sp_q <= 1'b0;
      prev_q     <= 8'h00;
      ver_byte_q <= 8'h00;
      acc_q      <= 10'd0;
      flags_q    <= '0;
      cr_q       <= 1'b0;
    end else if (valid_i) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      mask_q     <= mask_d;
      first_sp_q <= first_sp_d;
      later_sp_q <= later_sp_d;
      prev_q     <= prev_d;
      ver_byte_q <= ver_byte_d;
      acc_q      <= acc_d;
      flags_q    <= flags_d;
      cr_q       <= cr_d;
    end
  end

  assign result_o = res;

endmodule

@@ src/hslp_out_reg.sv @@
// Result register of the start line parser, held while the sink stalls.
module hslp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hslp_pkg::result_t   res_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hslp_pkg::out_item_t out_data_o
);

  logic                valid_q;
  hslp_pkg::out_item_t data_q;

  // Register may load when empty or when its result leaves this cycle
  assign take_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= res_i.valid;
    end
  end

  // Load payload on a new result only
  always_ff @(posedge clk_i) begin
    if (take_o && res_i.valid) begin
      data_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ src/http_start_line_parser.sv @@
// Top level of the HTTP start line parser.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid_i/in_stall_o  in_data_i (data_byte, message_start)
//   out      source     out_valid_o/out_stall_i out_data_o (outcome ... line_length)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (message_kind)
//
// One byte per clock unless stalled; input register, parse stage, then result register.
// The throughput is set by the single parse stage between input and result registers.
// Reset clears the parse to idle and message_kind to request; no clearing pass.
// A stall on a waiting result holds the result register and stalls the input in the same cycle.
module http_start_line_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hslp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hslp_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  logic               kind_q;
  logic               s1_valid_q;
  hslp_pkg::in_item_t s1_item_q;
  logic               take;
  hslp_pkg::result_t  res;

  // Configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      kind_q <= cfg_data_i;
    end
  end

  // Input register; stall when its byte cannot advance
  assign in_stall_o = s1_valid_q && !take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_data_i;
    end
  end

  hslp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q && take),
    .item_i   (s1_item_q),
    .kind_i   (kind_q),
    .result_o (res)
  );

  hslp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/hslp_checker.sv @@
// Port-level assertions of the start line parser and their bind.
`include "assert_macros.svh"

module hslp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hslp_pkg::out_item_t out_data_o
);

  // Stalled result stays put
  `HSLP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "result dropped or changed under stall")

  // Input stalls only behind a stalled result
  `HSLP_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output backpressure")

  // Error results carry no method, version or status
  `HSLP_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && (out_data_o.outcome != hslp_pkg::OutOk), (out_data_o.method_code == hslp_pkg::MethodUnknown) && (out_data_o.version_code == hslp_pkg::VerNone) && (out_data_o.status_number == 10'd0), "error result with payload")

  // Good results always name a version
  `HSLP_ASSERT_IMP(a_ok_ver, clk_i, rst_ni, out_valid_o && (out_data_o.outcome == hslp_pkg::OutOk), out_data_o.version_code != hslp_pkg::VerNone, "good result without version")

  // Response results carry no method
  `HSLP_ASSERT_IMP(a_rsp_nomethod, clk_i, rst_ni, out_valid_o && (out_data_o.status_number != 10'd0), out_data_o.method_code == hslp_pkg::MethodUnknown, "status and method together")

endmodule

bind http_start_line_parser hslp_checker u_hslp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench of the HTTP start line parser: byte stimulus, line prediction and result checks.

import hslp_pkg::*;

localparam bit KindRequest  = 1'b0;
localparam bit KindResponse = 1'b1;

// Method names in method code order, code = index + 1
function automatic string method_word(int unsigned idx);
  case (idx)
    0:       return "GET";
    1:       return "HEAD";
    2:       return "PUT";
    3:       return "DELETE";
    4:       return "OPTIONS";
    5:       return "TRACE";
    6:       return "POST";
    default: return "CONNECT";
  endcase
endfunction

// Tracks the start line parse byte by byte and checks the parser results in order
class line_scoreboard;
  typedef enum logic [1:0] {ScanIdle, ScanLine, ScanDone} scan_e;

  bit          kind;
  scan_e       line_state;
  int unsigned count;
  logic [7:0]  mask;
  logic [7:0]  prev;
  logic [7:0]  ver_b;
  int unsigned acc;
  bit          sp1, sp2, cr_seen;
  bit          st_started, st_digit, st_neg, st_ended;

  out_item_t   pending_lines[$];
  int unsigned errors, lines_checked, lines_queued, bytes_taken;
  int unsigned outcome_seen[8];

  function new();
    kind       = KindRequest;
    line_state = ScanIdle;
    clear_line();
  endfunction

  function void clear_line();
    count      = 0;
    mask       = 8'hFF;
    prev       = 8'h00;
    ver_b      = 8'h00;
    acc        = 0;
    sp1        = 1'b0;
    sp2        = 1'b0;
    cr_seen    = 1'b0;
    st_started = 1'b0;
    st_digit   = 1'b0;
    st_neg     = 1'b0;
    st_ended   = 1'b0;
  endfunction

  function logic [1:0] version_code_of(logic [7:0] b);
    case (b)
      CharZero: return Ver10;
      CharOne:  return Ver11;
      CharTwo:  return Ver20;
      default:  return VerNone;
    endcase
  endfunction

  function bit status_listed(int unsigned s);
    return s inside {100, 101, [200:206], [300:305], 307, [400:417], [500:505]};
  endfunction

  // Close the line with one expected result and ignore bytes until the next start
  function void queue_line(outcome_e oc, logic [3:0] me = MethodUnknown,
                           logic [1:0] ve = VerNone, logic [9:0] st = '0);
    out_item_t item;
    item.outcome       = oc;
    item.method_code   = me;
    item.version_code  = ve;
    item.status_number = st;
    item.line_length   = LenW'(count);
    pending_lines.push_back(item);
    lines_queued++;
    line_state = ScanDone;
  endfunction

  // Sign and decimal digits after the first space, leading blanks skipped
  function void scan_status(logic [7:0] b);
    bit digit;
    digit = (b >= CharZero) && (b <= CharNine);
    if (st_ended) return;
    if (!st_started) begin
      if (b inside {CharSpace, CharTab, CharLf, CharVt, CharFf}) return;
      if (b == CharPlus || b == CharMinus) begin
        st_started = 1'b1;
        st_neg     = (b == CharMinus);
      end else if (digit) begin
        st_started = 1'b1;
        st_digit   = 1'b1;
        acc        = b - CharZero;
      end else begin
        st_ended = 1'b1;
      end
    end else if (digit) begin
      acc      = acc * 10 + (b - CharZero);
      acc      = (acc > 1023) ? 1023 : acc;
      st_digit = 1'b1;
    end else begin
      st_ended = 1'b1;
    end
  endfunction

  // Any byte of the line other than CR
  function void plain_byte(logic [7:0] b);
    int unsigned pos;
    string w;
    pos = count - 1;
    if (!sp1) begin
      if (b == CharSpace) begin
        sp1   = 1'b1;
        ver_b = prev;
        for (int i = 0; i < 8; i++)
          if (method_word(i).len() != pos) mask[i] = 1'b0;
      end else begin
        for (int i = 0; i < 8; i++) begin
          w = method_word(i);
          if (pos >= w.len() || w[pos] != b) mask[i] = 1'b0;
        end
      end
    end else begin
      if (b == CharSpace) sp2 = 1'b1;
      scan_status(b);
    end
    prev = b;
  endfunction

  // CR LF seen: grade the line under the kind in force now
  function void close_line();
    logic [1:0] v;
    logic [3:0] m;
    m = MethodUnknown;
    if (!sp1) begin
      queue_line(OutNoFirstSpace);
    end else if (kind == KindRequest) begin
      v = version_code_of(prev);
      if (!sp2) begin
        queue_line(OutNoSecondSpace);
      end else if (v == VerNone) begin
        queue_line(OutBadVersion);
      end else begin
        for (int i = 7; i >= 0; i--)
          if (mask[i]) m = 4'(i + 1);
        queue_line(OutOk, m, v);
      end
    end else begin
      v = version_code_of(ver_b);
      if (v == VerNone) queue_line(OutBadVersion);
      else if (!st_digit || st_neg || !status_listed(acc)) queue_line(OutBadStatus);
      else queue_line(OutOk, MethodUnknown, v, 10'(acc));
    end
  endfunction

  // Advance the parse by one transferred byte
  function void take_byte(in_item_t it);
    logic [7:0] b;
    b = it.data_byte;
    bytes_taken++;
    if (it.message_start) begin
      clear_line();
      line_state = ScanLine;
    end
    if (line_state != ScanLine) return;
    count++;
    if (cr_seen) begin
      if (b == CharLf) close_line();
      else queue_line(OutCrNoLf);
      return;
    end
    if (b == CharCr) cr_seen = 1'b1;
    else plain_byte(b);
    if (count >= MaxLine) queue_line(OutTooLong);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void match_result(out_item_t got);
    out_item_t want;
    if (pending_lines.size() == 0) begin
      $error("result with no line pending: outcome %0d, line_length %0d",
             got.outcome, got.line_length);
      errors++;
      return;
    end
    want = pending_lines.pop_front();
    lines_checked++;
    outcome_seen[want.outcome]++;
    compare_field("outcome", want.outcome, got.outcome);
    compare_field("method_code", want.method_code, got.method_code);
    compare_field("version_code", want.version_code, got.version_code);
    compare_field("status_number", want.status_number, got.status_number);
    compare_field("line_length", want.line_length, got.line_length);
  endfunction
endclass

module tb;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 4;
  localparam string       Eol         = "\015\012";

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned line_bytes     = 0;
  int unsigned send_pcts[4]   = '{0, 65, 0, 12};
  int unsigned recv_pcts[4]   = '{0, 0, 65, 12};
  logic [7:0]  line_buf[$];

  line_scoreboard board = new();

  http_start_line_parser DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Observe each transfer, feed the scoreboard and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.take_byte(in_data);
      if (out_valid && !out_stall) board.match_result(out_data);
      if (cfg_valid && cfg_ready) board.kind = cfg_data;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $error("no transfer for %0d cycles", quiet_cycles);
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  // Byte buffer builders
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_word(int unsigned n);
    repeat (n) line_buf.push_back(8'($urandom_range(33, 126)));
  endfunction

  function automatic logic [7:0] version_char();
    if ($urandom_range(99) < 85) return CharZero + 8'($urandom_range(2));
    return 8'($urandom_range(33, 126));
  endfunction

  // Mostly CR LF; sometimes CR with a stray byte, sometimes a cut line
  function automatic void end_line();
    int unsigned r;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 88) begin
      line_buf.push_back(CharCr);
      line_buf.push_back(CharLf);
    end else if (r < 94) begin
      b = 8'($urandom_range(255));
      line_buf.push_back(CharCr);
      line_buf.push_back((b == CharLf) ? CharCr : b);
    end
  endfunction

  function automatic void make_request();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) begin
      add_text(method_word($urandom_range(7)));
    end else if (r < 88) begin
      add_text(method_word($urandom_range(7)));
      if ($urandom_range(1)) void'(line_buf.pop_back());
      else line_buf.push_back(8'($urandom_range(33, 126)));
    end else begin
      add_word($urandom_range(1, 8));
    end
    if ($urandom_range(99) < 5) begin
      end_line();
      return;
    end
    add_text(" /");
    add_word($urandom_range(0, 3));
    if ($urandom_range(99) < 8) begin
      end_line();
      return;
    end
    add_text(" HTTP/1.");
    line_buf.push_back(version_char());
    if ($urandom_range(99) < 5) line_buf.push_back(CharSpace);
    end_line();
  endfunction

  function automatic void make_response();
    int unsigned r, st;
    r = $urandom_range(99);
    if (r < 88) begin
      add_text("HTTP/1.");
      line_buf.push_back(version_char());
    end else if (r >= 94) begin
      add_word($urandom_range(1, 6));
    end
    line_buf.push_back(CharSpace);
    // leading blanks ahead of the status
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(4))
          0:       line_buf.push_back(CharSpace);
          1:       line_buf.push_back(CharTab);
          2:       line_buf.push_back(CharLf);
          3:       line_buf.push_back(CharVt);
          default: line_buf.push_back(CharFf);
        endcase
      end
    end
    r = $urandom_range(99);
    if (r < 8) line_buf.push_back(CharPlus);
    else if (r < 13) line_buf.push_back(CharMinus);
    r = $urandom_range(99);
    if (r < 72) begin
      case ($urandom_range(4))
        0:       st = 100 + $urandom_range(1);
        1:       st = 200 + $urandom_range(6);
        2:       st = ($urandom_range(6) == 6) ? 307 : 300 + $urandom_range(5);
        3:       st = 400 + $urandom_range(17);
        default: st = 500 + $urandom_range(5);
      endcase
      add_text($sformatf("%0d", st));
    end else if (r < 86) begin
      add_text($sformatf("%0d", $urandom_range(1023)));
    end else if (r < 94) begin
      add_text($sformatf("%0d", $urandom_range(1000, 99999)));
    end
    if ($urandom_range(1)) begin
      line_buf.push_back(CharSpace);
      add_word($urandom_range(0, 4));
    end
    end_line();
  endfunction

  // Transfer one byte, then sometimes idle the sender for a random stretch
  task automatic send_byte(input logic [7:0] b, input bit start);
    in_data  <= in_item_t'{data_byte: b, message_start: start};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_buf(input bit with_start);
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], with_start && i == 0);
    line_buf.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_buf(1'b1);
  endtask

  // Hold until every predicted line has come back, then let the pipeline settle
  task automatic wait_drain();
    do @(posedge clk); while (board.pending_lines.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_kind(input bit k);
    in_valid <= 1'b0;
    wait_drain();
    cfg_data  <= k;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_message(input bit k);
    int unsigned r;
    r = $urandom_range(99);
    if (r >= 92) begin
      // stray bytes with no message start
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(255)));
      send_buf(1'b0);
    end else begin
      if (r < 80) begin
        if ((r < 70) ^ (k == KindRequest)) make_response();
        else make_request();
      end else begin
        repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(255)));
        if ($urandom_range(1)) begin
          line_buf.push_back(CharCr);
          line_buf.push_back(8'($urandom_range(255)));
        end
      end
      line_bytes += line_buf.size();
      send_buf(1'b1);
      // trailing header bytes, dropped once the line is done
      repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(255)));
      send_buf(1'b0);
    end
  endtask

  initial begin
    int unsigned base_bytes, base_lines;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_kind(KindRequest);

    // Bytes before any message start are dropped
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back("G");
    send_buf(1'b0);

    // Every method and version, then malformed request lines
    send_text({"GET / HTTP/1.1", Eol});
    add_text("Host: a");
    send_buf(1'b0);
    send_text({"HEAD /a HTTP/1.0", Eol});
    send_text({"PUT /x HTTP/2", Eol});
    send_text({"DELETE / HTTP/1.1", Eol});
    send_text({"OPTIONS * HTTP/1.0", Eol});
    send_text({"TRACE / HTTP/1.1", Eol});
    send_text({"POST /f HTTP/1.1", Eol});
    send_text({"CONNECT h:1 HTTP/1.1", Eol});
    send_text({"get / HTTP/1.1", Eol});
    send_text({"NOSPACE", Eol});
    send_text({"GET /", Eol});
    send_text({"GET / HTTP/1.1 ", Eol});
    send_text({"GET / HTTP/1.9", Eol});
    send_text("GET / HTTP/1.1\015X");
    line_buf.push_back(8'h00);
    line_buf.push_back(8'hFF);
    line_buf.push_back(CharCr);
    line_buf.push_back(CharLf);
    send_buf(1'b1);

    // A message start in the middle of a line restarts the parse
    send_text("GET / HT");
    send_text({"POST / HTTP/1.0", Eol});

    // The kind in force at LF decides how the line is graded
    send_text("HTTP/1.1 200 OK\015");
    set_kind(KindResponse);
    line_buf.push_back(CharLf);
    send_buf(1'b0);

    // Status lines: versions, signs, blanks, unknown codes, saturation
    send_text({"HTTP/1.0 404 Not Found", Eol});
    send_text({"HTTP/2 307", Eol});
    send_text({" 200 OK", Eol});
    send_text({"HTTP/1.1 999 X", Eol});
    send_text({"HTTP/1.1 -200", Eol});
    send_text({"HTTP/1.1 +505 X", Eol});
    send_text({"HTTP/1.1 \t\013\014 100", Eol});
    send_text({"HTTP/1.1 OK", Eol});
    send_text({"HTTP/1.1 99999", Eol});

    // Lines at the length limit: too long, complete at the last byte, CR without LF there
    set_kind(KindRequest);
    repeat (MaxLine) line_buf.push_back("A");
    send_buf(1'b1);
    add_text("GET /");
    while (line_buf.size() < MaxLine - 11) line_buf.push_back("a");
    send_text({" HTTP/1.1", Eol});
    repeat (MaxLine - 2) line_buf.push_back("A");
    send_text("\015X");

    // Random messages under every idling mix and both kinds
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 2; k++) begin
        send_idle_pct  = send_pcts[ph];
        recv_stall_pct = recv_pcts[ph];
        set_kind(k[0]);
        base_bytes = line_bytes;
        base_lines = board.lines_queued;
        while (line_bytes - base_bytes < 70 || board.lines_queued - base_lines < 8)
          random_message(k[0]);
      end
    end

    in_valid <= 1'b0;
    wait_drain();

    $display("tb: %0d bytes transferred, %0d start lines checked over both message kinds",
             board.bytes_taken, board.lines_checked);
    $display({"tb: outcomes ok %0d, no first space %0d, no second space %0d, ",
              "bad version %0d, bad status %0d, CR without LF %0d, too long %0d"},
             board.outcome_seen[OutOk], board.outcome_seen[OutNoFirstSpace],
             board.outcome_seen[OutNoSecondSpace], board.outcome_seen[OutBadVersion],
             board.outcome_seen[OutBadStatus], board.outcome_seen[OutCrNoLf],
             board.outcome_seen[OutTooLong]);
    if (board.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
